/* hw/rtl/msg_pkg.sv */
// ----------------------------------------------------------------------------
// msg_pkg
// Shared types, constants and helpers of the maximal-length sequence generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msg_pkg;

  localparam int MAX_BITS   = 31;
  localparam int CELLS      = MAX_BITS + 1;
  localparam int NB_W       = 5;
  localparam int TAP_W      = 32;
  localparam int MODE_W     = 2;
  localparam int REP_W      = 16;
  localparam int STEP_W     = MAX_BITS;
  localparam int GEN_W      = 32;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [NB_W-1:0]  BITS_RESET = NB_W'(10);
  localparam logic [NB_W-1:0]  BITS_MIN   = NB_W'(2);
  localparam logic [REP_W-1:0] REP_RESET  = REP_W'(1);

  localparam logic [1:0] REG_BITS   = 2'd0;
  localparam logic [1:0] REG_TAPS   = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;
  localparam logic [1:0] REG_REPEAT = 2'd3;

  localparam logic [MODE_W-1:0] MODE_FULL    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BIT     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BIPOLAR = 2'd2;

  typedef struct packed {
    logic [NB_W-1:0]   bits_in_use;
    logic [TAP_W-1:0]  tap_mask;
    logic [MODE_W-1:0] output_mode;
    logic [REP_W-1:0]  repeat_count;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic restart;
    logic advance;
    logic reload;
  } cell_ctl_t;

  function automatic logic [NB_W-1:0] eff_bits(input logic [NB_W-1:0] n);
    eff_bits = (n < BITS_MIN) ? BITS_MIN : n;
  endfunction

  function automatic logic [MAX_BITS-1:0] len_mask(input logic [NB_W-1:0] n);
    logic [MAX_BITS:0] one_hot;
    one_hot  = (MAX_BITS+1)'(1) << n;
    len_mask = MAX_BITS'(one_hot - (MAX_BITS+1)'(1));
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/msg_if.sv */
// ----------------------------------------------------------------------------
// msg_if
// Valid/ready channels of the sequence generator: request and sample beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface msg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface msg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gen_value;
  logic        [30:0] tap_value;
  logic               period_end;

  modport source (output valid, output gen_value, output tap_value,
                  output period_end, input ready);
  modport sink   (input valid, input gen_value, input tap_value,
                  input period_end, output ready);
endinterface

`default_nettype wire

/* hw/rtl/m_sequence_generator.sv */
// ----------------------------------------------------------------------------
// m_sequence_generator
// Maximal-length sequence generator with Fibonacci and Galois registers.
//
// Each request beat on in_ch (restart bit) produces one sample beat on
// out_ch: gen_value, tap_value and period_end. restart = 1 reloads both
// registers to 1 and clears the counters before that sample is formed.
// Every sequence value is repeated repeat_count times (once if zero);
// period_end marks the last sample of a period of 2^n-1 values, after
// which both registers reload. output_mode selects full states, the low
// bit, or +1/-1; mode 3 gives zero. The sample is registered in the cycle
// after its request is accepted; one beat is taken every cycle unless
// the receiver stalls. The sample register is refilled while the receiver
// takes the old beat; if the receiver stalls, the request channel stalls
// with it. After reset: n = 10, taps 0, mode 0, repeat 1, registers at 1.
// Program the APB registers only while no beat is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module m_sequence_generator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  msg_in_if.sink                          in_ch,
  msg_out_if.source                       out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [msg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [msg_pkg::DATA_W-1:0] pwdata,
  output logic      [msg_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import msg_pkg::*;

  cfg_t             cfg;
  cell_ctl_t        ctl;
  logic             accept, period_end;
  logic [NB_W-1:0]  n_eff;
  logic [CELLS-1:0] in_use, is_top, fib_bit, gal_bit, fib_term;
  logic             fib_fb, gal_fb;
  logic [MAX_BITS-1:0] fib_state, gal_state;
  logic signed [GEN_W-1:0] gen_nxt;
  logic [MAX_BITS-1:0]     tap_nxt;

  logic                    out_valid_r;
  logic signed [GEN_W-1:0] gen_r;
  logic [MAX_BITS-1:0]     tap_r;
  logic                    pend_r;

  msg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign n_eff        = eff_bits(cfg.bits_in_use);
  assign in_ch.ready  = ~out_valid_r | out_ch.ready;
  assign accept       = in_ch.valid & in_ch.ready;

  msg_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .restart      (in_ch.restart),
    .n_eff        (n_eff),
    .repeat_count (cfg.repeat_count),
    .ctl          (ctl),
    .period_end   (period_end)
  );

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic fib_left, gal_right;

    assign in_use[i] = {1'b0, n_eff} > (NB_W+1)'(i);
    assign is_top[i] = {1'b0, n_eff} == (NB_W+1)'(i + 1);

    if (i == CELLS - 1) begin : g_msb
      assign fib_left = 1'b0;
    end else begin : g_mid
      assign fib_left = fib_bit[i+1];
    end

    if (i == 0) begin : g_lsb
      assign gal_right = 1'b0;
    end else begin : g_up
      assign gal_right = gal_bit[i-1];
    end

    msg_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .seed      (i == 0),
      .in_use    (in_use[i]),
      .is_top    (is_top[i]),
      .tap       (cfg.tap_mask[i]),
      .fib_left  (fib_left),
      .fib_fb    (fib_fb),
      .gal_right (gal_right),
      .gal_fb    (gal_fb),
      .fib_bit   (fib_bit[i]),
      .gal_bit   (gal_bit[i]),
      .fib_term  (fib_term[i])
    );
  end

  assign fib_fb    = ^fib_term;
  assign gal_fb    = |(gal_bit & is_top);
  assign fib_state = fib_bit[MAX_BITS-1:0];
  assign gal_state = gal_bit[MAX_BITS-1:0] & in_use[MAX_BITS-1:0];

  always_comb begin
    gen_nxt = '0;
    tap_nxt = '0;
    case (cfg.output_mode)
      MODE_FULL: begin
        gen_nxt = GEN_W'(fib_state);
        tap_nxt = gal_state;
      end
      MODE_BIT:     gen_nxt = GEN_W'(fib_state[0]);
      MODE_BIPOLAR: gen_nxt = fib_state[0] ? -GEN_W'(1) : GEN_W'(1);
      default: begin
        gen_nxt = '0;
        tap_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gen_r  <= gen_nxt;
      tap_r  <= tap_nxt;
      pend_r <= period_end;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.gen_value  = gen_r;
  assign out_ch.tap_value  = tap_r;
  assign out_ch.period_end = pend_r;

endmodule

`default_nettype wire

/* hw/rtl/msg_regs.sv */
// ----------------------------------------------------------------------------
// msg_regs
// APB-style configuration registers: length, taps, output mode and repeat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [msg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [msg_pkg::DATA_W-1:0] pwdata,
  output logic      [msg_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output msg_pkg::cfg_t                   cfg
);
  import msg_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_BITS:   cfg_nxt.bits_in_use  = pwdata[NB_W-1:0];
        REG_TAPS:   cfg_nxt.tap_mask     = pwdata[TAP_W-1:0];
        REG_MODE:   cfg_nxt.output_mode  = pwdata[MODE_W-1:0];
        REG_REPEAT: cfg_nxt.repeat_count = pwdata[REP_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BITS:   prdata = DATA_W'(cfg_r.bits_in_use);
      REG_TAPS:   prdata = DATA_W'(cfg_r.tap_mask);
      REG_MODE:   prdata = DATA_W'(cfg_r.output_mode);
      REG_REPEAT: prdata = DATA_W'(cfg_r.repeat_count);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bits_in_use  <= BITS_RESET;
      cfg_r.tap_mask     <= '0;
      cfg_r.output_mode  <= MODE_FULL;
      cfg_r.repeat_count <= REP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/msg_ctrl.sv */
// ----------------------------------------------------------------------------
// msg_ctrl
// Hold and step counters; decide per beat whether the cell row holds,
// advances or reloads, and flag the last sample of a period.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msg_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire logic                      restart,
  input  wire logic [msg_pkg::NB_W-1:0]  n_eff,
  input  wire logic [msg_pkg::REP_W-1:0] repeat_count,
  output msg_pkg::cell_ctl_t             ctl,
  output logic                           period_end
);
  import msg_pkg::*;

  logic [REP_W-1:0]  hold_r,  hold_nxt,  hold_eff, rep_m1;
  logic [STEP_W-1:0] step_r,  step_nxt,  step_eff, last_step;
  logic              hold_done, period_done;

  assign hold_eff    = restart ? '0 : hold_r;
  assign step_eff    = restart ? '0 : step_r;
  assign rep_m1      = (repeat_count == '0) ? '0 : repeat_count - REP_W'(1);
  assign last_step   = len_mask(n_eff) - STEP_W'(1);
  assign hold_done   = hold_eff >= rep_m1;
  assign period_done = step_eff >= last_step;
  assign period_end  = hold_done & period_done;

  assign ctl.accept  = accept;
  assign ctl.restart = restart;
  assign ctl.advance = hold_done & ~period_done;
  assign ctl.reload  = hold_done & period_done;

  always_comb begin
    hold_nxt = hold_r;
    step_nxt = step_r;
    if (accept) begin
      if (!hold_done) begin
        hold_nxt = hold_eff + REP_W'(1);
        step_nxt = step_eff;
      end else if (period_done) begin
        hold_nxt = '0;
        step_nxt = '0;
      end else begin
        hold_nxt = '0;
        step_nxt = step_eff + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
      step_r <= '0;
    end else begin
      hold_r <= hold_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/msg_cell.sv */
// ----------------------------------------------------------------------------
// msg_cell
// One bit position of both shift registers: a Fibonacci bit fed from the
// left neighbour and a Galois bit fed from the right neighbour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msg_cell (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire msg_pkg::cell_ctl_t ctl,
  input  wire logic         seed,
  input  wire logic         in_use,
  input  wire logic         is_top,
  input  wire logic         tap,
  input  wire logic         fib_left,
  input  wire logic         fib_fb,
  input  wire logic         gal_right,
  input  wire logic         gal_fb,
  output logic              fib_bit,
  output logic              gal_bit,
  output logic              fib_term
);
  import msg_pkg::*;

  logic fib_r, fib_nxt, fib_eff;
  logic gal_r, gal_nxt;

  assign fib_eff  = ctl.restart ? seed : fib_r;
  assign fib_bit  = fib_eff & in_use;
  assign gal_bit  = ctl.restart ? seed : gal_r;
  assign fib_term = fib_bit & tap;

  always_comb begin
    fib_nxt = fib_r;
    gal_nxt = gal_r;
    if (ctl.accept) begin
      if (ctl.reload) begin
        fib_nxt = seed;
        gal_nxt = seed;
      end else if (ctl.advance) begin
        fib_nxt = is_top ? fib_fb : fib_left;
        gal_nxt = gal_right ^ (gal_fb & tap);
      end else begin
        fib_nxt = fib_eff;
        gal_nxt = gal_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fib_r <= seed;
      gal_r <= seed;
    end else begin
      fib_r <= fib_nxt;
      gal_r <= gal_nxt;
    end
  end

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the maximal-length sequence generator: request beats
// go in with random restarts, every sample beat is checked against a
// cycle-free register model kept in step with the APB settings, under random
// stalls on both channels and a long hold-off of the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import msg_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF    = 300;
  localparam int PHASE_BEATS = 150;

  typedef struct {
    logic signed [31:0] gen_value;
    logic        [30:0] tap_value;
    logic               period_end;
  } sample_t;

  class sample_board;
    logic [NB_W-1:0]   bits;
    logic [TAP_W-1:0]  taps;
    logic [MODE_W-1:0] mode;
    logic [REP_W-1:0]  repeats;
    logic [30:0]       fib;
    logic [31:0]       gal;
    logic [15:0]       hold;
    logic [30:0]       step_count;
    sample_t           pending[$];
    int                errors;

    function new();
      bits    = BITS_RESET;
      taps    = '0;
      mode    = MODE_FULL;
      repeats = REP_RESET;
      errors  = 0;
      reload();
    endfunction

    function void reload();
      fib        = 31'd1;
      gal        = 32'd1;
      hold       = '0;
      step_count = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_BITS:   bits = value[NB_W-1:0];
        REG_TAPS:   taps = value;
        REG_MODE:   mode = value[MODE_W-1:0];
        REG_REPEAT: repeats = value[REP_W-1:0];
        default: ;
      endcase
    endfunction

    // form the sample of one request, then hold, advance or reload both registers
    function void note_request(logic restart);
      int unsigned n;
      logic [31:0] mask, last, rep, fm, gen, tap, g;
      bit          hold_done, period_done;
      sample_t     s;
      n    = (bits < BITS_MIN) ? 2 : int'(bits);
      mask = 32'((64'd1 << n) - 64'd1);
      last = mask - 32'd1;
      rep  = (repeats == 0) ? 32'd1 : {16'd0, repeats};
      if (restart) reload();
      fm  = {1'b0, fib} & mask;
      gen = '0;
      tap = '0;
      case (mode)
        MODE_FULL: begin
          gen = fm;
          tap = gal & mask;
        end
        MODE_BIT:     gen = {31'd0, fm[0]};
        MODE_BIPOLAR: gen = fm[0] ? 32'hFFFF_FFFF : 32'd1;
        default: ;
      endcase
      hold_done   = {16'd0, hold} >= rep - 32'd1;
      period_done = {1'b0, step_count} >= last;
      s.gen_value  = gen;
      s.tap_value  = tap[30:0];
      s.period_end = hold_done && period_done;
      pending.push_back(s);
      if (!hold_done) begin
        hold = hold + 16'd1;
      end else if (period_done) begin
        reload();
      end else begin
        hold       = '0;
        step_count = step_count + 31'd1;
        fib        = 31'((fm >> 1) | (32'(^(fm & taps)) << (n - 1)));
        g          = {gal[30:0], 1'b0};
        if (g[n]) g = g ^ taps;
        gal = g;
      end
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_sample(logic signed [31:0] gen, logic [30:0] tap, logic pend);
      sample_t want;
      if (pending.size() == 0) begin
        report($sformatf("sample gen=%0d tap=%0h with no request pending", gen, tap));
        return;
      end
      want = pending.pop_front();
      if (gen !== want.gen_value)
        report($sformatf("gen_value %0d, want %0d", gen, want.gen_value));
      if (tap !== want.tap_value)
        report($sformatf("tap_value %0h, want %0h", tap, want.tap_value));
      if (pend !== want.period_end)
        report($sformatf("period_end %0b, want %0b", pend, want.period_end));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  msg_in_if  in_ch ();
  msg_out_if out_ch ();

  m_sequence_generator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sample_board board = new();
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int hold_left;
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver: random ready, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_OFF;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      board.note_request(in_ch.restart);
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_sample(out_ch.gen_value, out_ch.tap_value, out_ch.period_end);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[m_sequence_generator] ERROR");
      $finish;
    end
  end

  // valid stays high after the beat so that the next one can follow at once
  task automatic send_request(input logic restart);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // drop the request, drain every sample, then let the output stage go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic shuffle_settings();
    int r;
    r = $urandom_range(0, 9);
    if ($urandom_range(0, 1))
      write_reg(REG_BITS, (r < 6) ? $urandom_range(0, 6) :
                          (r < 9) ? $urandom_range(7, 12) : $urandom_range(0, 31));
    if ($urandom_range(0, 1))
      write_reg(REG_TAPS, $urandom);
    if ($urandom_range(0, 1))
      write_reg(REG_MODE, $urandom_range(0, 3));
    r = $urandom_range(0, 9);
    if ($urandom_range(0, 1))
      write_reg(REG_REPEAT, (r < 6) ? $urandom_range(0, 3) :
                            (r < 9) ? $urandom_range(4, 12) : $urandom_range(0, 65535));
  endtask

  initial begin
    int burst;
    int sent;
    bit pressed;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    out_ch.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_req      = 1'b0;
    hold_left     = 0;
    quiet_cycles  = 0;
    send_idle_pct = 33;
    recv_idle_pct = 86;
    pressed       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // settings straight out of reset
    send_request(1'b0);
    send_request(1'b1);
    settle();

    // length below two, zero repeat, period wrap
    write_reg(REG_BITS, 0);
    write_reg(REG_TAPS, 32'h3);
    write_reg(REG_REPEAT, 0);
    repeat (6) send_request(1'b0);
    settle();

    write_reg(REG_BITS, 1);
    write_reg(REG_MODE, MODE_BIT);
    write_reg(REG_REPEAT, 2);
    repeat (4) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    settle();

    write_reg(REG_BITS, 3);
    write_reg(REG_TAPS, 32'h6);
    write_reg(REG_MODE, MODE_BIPOLAR);
    write_reg(REG_REPEAT, 1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    settle();

    write_reg(REG_BITS, 31);
    write_reg(REG_TAPS, 32'hFFFF_FFFF);
    write_reg(REG_MODE, MODE_FULL);
    repeat (4) send_request(1'b0);
    settle();

    // shrink the length mid-period
    write_reg(REG_BITS, 2);
    repeat (2) send_request(1'b0);
    settle();

    write_reg(REG_MODE, MODE_UNUSED);
    write_reg(REG_REPEAT, 65535);
    repeat (2) send_request(1'b0);
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 86 : 0;
      recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 33 : 0;
      sent = 0;
      while (sent < PHASE_BEATS) begin
        settle();
        shuffle_settings();
        burst = $urandom_range(8, 30);
        if (phase == 2 && !pressed) begin
          pressed  = 1'b1;
          hold_req = 1'b1;
          burst    = 24;
        end
        repeat (burst) send_request($urandom_range(0, 19) == 0);
        sent += burst;
      end
    end

    settle();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("[m_sequence_generator] OK");
    else
      $display("[m_sequence_generator] ERROR");
    $finish;
  end

endmodule
